// ----- hdl/rmem_pkg.sv -----
// ----------------------------------------------------------------------------
// rmem_pkg
// Shared types and constants of the rotation mark energy meter.
// ----------------------------------------------------------------------------
package rmem_pkg;

    // default parameter values
    localparam int WINDOW_DEF = 2;
    localparam int READS_DEF  = 5;

    // stream widths (whole bytes)
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 88;

    // config port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_ROT_PER_KWH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_MS = 2'd1;
    localparam logic [15:0] ROT_PER_KWH_RST = 16'd75;
    localparam logic [15:0] DEBOUNCE_MS_RST = 16'd20;

    // power = POWER_NUM / (period * rotations_per_kwh)
    localparam logic [31:0] POWER_NUM = 32'd3600000000;
    localparam logic [31:0] POWER_SAT = 32'd3600000000;
    localparam int DIV_W     = 48;
    localparam int DIV_STEPS = 32;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    // output tdata bit positions
    localparam int OB_MARK   = 0;
    localparam int OB_LOCKED = 1;
    localparam int OB_PVALID = 2;
    localparam int OB_POWER  = 3;
    localparam int OB_ROT    = 35;
    localparam int OB_KWH    = 51;
    localparam int OB_KSTEP  = 83;

    // input tuser codes
    localparam logic ACT_TICK   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    // mark states
    localparam logic MARK_SILVER = 1'b0;
    localparam logic MARK_RED    = 1'b1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_EVAL  = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_WRITE = 5'b10000
    } t_state;

endpackage

// ----- hdl/rotation_mark_energy_meter.sv -----
// ----------------------------------------------------------------------------
// rotation_mark_energy_meter
// One channel of a rotating-disc meter reader: read voting, mark tracking
// with debounce lockout, disc period, power, rotation and kWh counting.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake                     | payload
//  ----------+-----+-------------------------------+-----------------------------
//  s_axis    | in  | s_axis_tvalid / s_axis_tready | tuser: action, tdata: reads
//  m_axis    | out | m_axis_tvalid / m_axis_tready | tdata: result fields
//  cfg       | in  | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
//  A tick or a sample without a measured rotation goes from transfer through
//  evaluation to output load; a sample that measures a rotation also passes
//  the multiply state and the 32-step restoring divider (one quotient bit per
//  cycle), which is skipped when the divisor is zero and power saturates.
//  s_axis_tready is low while an item is in work. The
//  output register holds a result until it is taken; the next item is
//  accepted meanwhile and waits only at its own output load. Reset is
//  synchronous, active low; config is always ready.
//
module rotation_mark_energy_meter
    import rmem_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF,  // votes in the majority window, 1..16
    parameter int READS  = READS_DEF    // sensor reads used per sample, 1..5
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // sample / tick stream
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [4:0] sensor_reads
    input  logic                   s_axis_tuser,   // [0] action
    // result stream
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [0] mark_state, [1] locked, [2] power_valid, [34:3] power_w,
    // [50:35] rotations_in_kwh, [82:51] kwh_total, [83] kwh_step
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int RCNT_W = $clog2(READS + 1);
    localparam int WCNT_W = $clog2(WINDOW + 1);

    // sequencer
    t_state r_state, n_state;

    // config registers
    logic [15:0] r_rpk, r_deb;

    // meter state
    logic [WINDOW-1:0] r_win, n_win;
    logic        r_mark, n_mark;
    logic        r_lock, n_lock;
    logic [31:0] r_lock_start, n_lock_start;
    logic [31:0] r_now, n_now;
    logic [31:0] r_last, n_last;
    logic        r_first, n_first;
    logic [15:0] r_rot, n_rot;
    logic [31:0] r_kwh, n_kwh;
    logic [31:0] r_power, n_power;
    logic        r_pvalid, n_pvalid;
    logic        r_kstep, n_kstep;

    // captured item
    logic        r_in_act;
    logic [4:0]  r_in_reads;

    // divider datapath
    logic [31:0]       r_period, n_period;
    logic [DIV_W-1:0]  r_div, n_div;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [31:0]       r_nq, n_nq;    // numerator bits out at top, quotient in at bottom
    logic [STEP_W-1:0] r_step, n_step;

    // output register
    logic                   r_out_valid, n_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic s_xfer;
    logic out_load;

    // vote and level
    logic [RCNT_W-1:0] read_ones;
    logic [WCNT_W-1:0] win_ones;
    logic              vote;
    logic              level;

    // divider step
    logic [DIV_W:0]    trial;
    logic              qbit;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_xfer        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign out_load      = (r_state == ST_WRITE) && (!r_out_valid || m_axis_tready);

    // read majority, then window majority including the new vote
    always_comb begin
        read_ones = '0;
        for (int i = 0; i < READS; i++) begin
            read_ones = read_ones + RCNT_W'(r_in_reads[i]);
        end
        vote = (read_ones > RCNT_W'(READS / 2));
        n_win[0] = vote;
        for (int i = 1; i < WINDOW; i++) begin
            n_win[i] = r_win[i-1];
        end
        win_ones = '0;
        for (int i = 0; i < WINDOW; i++) begin
            win_ones = win_ones + WCNT_W'(n_win[i]);
        end
        level = (win_ones > WCNT_W'(WINDOW / 2));
    end

    // one restoring divide step
    always_comb begin
        trial = {r_rem, r_nq[31]};
        qbit  = (trial >= {1'b0, r_div});
    end

    always_comb begin
        n_state      = r_state;
        n_mark       = r_mark;
        n_lock       = r_lock;
        n_lock_start = r_lock_start;
        n_now        = r_now;
        n_last       = r_last;
        n_first      = r_first;
        n_rot        = r_rot;
        n_kwh        = r_kwh;
        n_power      = r_power;
        n_pvalid     = r_pvalid;
        n_kstep      = r_kstep;
        n_period     = r_period;
        n_div        = r_div;
        n_rem        = r_rem;
        n_nq         = r_nq;
        n_step       = r_step;

        unique case (r_state)
            ST_IDLE: begin
                if (s_xfer) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_pvalid = 1'b0;
                n_kstep  = 1'b0;
                n_state  = ST_WRITE;
                if (r_in_act == ACT_TICK) begin
                    n_now = r_now + 32'd1;
                    if (r_lock && ((n_now - r_lock_start) > {16'd0, r_deb})) begin
                        n_lock = 1'b0;
                    end
                end else if (!r_lock) begin
                    if ((r_mark == MARK_SILVER) && !level) begin
                        // silver to red: one disc rotation
                        n_mark       = MARK_RED;
                        n_lock       = 1'b1;
                        n_lock_start = r_now;
                        n_last       = r_now;
                        n_period     = r_now - r_last;
                        if (r_first) begin
                            n_first = 1'b0;     // time base only
                        end else begin
                            n_pvalid = 1'b1;
                            n_state  = ST_MUL;
                            if (r_rot < r_rpk) begin
                                n_rot = r_rot + 16'd1;
                            end else begin
                                n_kwh   = r_kwh + 32'd1;
                                n_rot   = 16'd1;
                                n_kstep = 1'b1;
                            end
                        end
                    end else if ((r_mark == MARK_RED) && level) begin
                        n_mark       = MARK_SILVER;
                        n_lock       = 1'b1;
                        n_lock_start = r_now;
                    end
                end
            end
            ST_MUL: begin
                n_div  = {16'd0, r_period} * {32'd0, r_rpk};
                n_rem  = '0;
                n_nq   = POWER_NUM;
                n_step = '0;
                if ((r_period == 32'd0) || (r_rpk == 16'd0)) begin
                    n_power = POWER_SAT;
                    n_state = ST_WRITE;
                end else begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                n_rem  = qbit ? DIV_W'(trial - {1'b0, r_div}) : DIV_W'(trial);
                n_nq   = {r_nq[30:0], qbit};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_power = n_nq;
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = (r_out_valid && !m_axis_tready) || out_load;
        n_out_data  = r_out_data;
        if (out_load) begin
            n_out_data                     = '0;
            n_out_data[OB_MARK]            = r_mark;
            n_out_data[OB_LOCKED]          = r_lock;
            n_out_data[OB_PVALID]          = r_pvalid;
            n_out_data[OB_POWER +: 32]     = r_power;
            n_out_data[OB_ROT +: 16]       = r_rot;
            n_out_data[OB_KWH +: 32]       = r_kwh;
            n_out_data[OB_KSTEP]           = r_kstep;
        end
    end

    // control and meter state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_rpk        <= ROT_PER_KWH_RST;
            r_deb        <= DEBOUNCE_MS_RST;
            r_win        <= '0;
            r_mark       <= MARK_RED;
            r_lock       <= 1'b0;
            r_lock_start <= '0;
            r_now        <= '0;
            r_last       <= '0;
            r_first      <= 1'b1;
            r_rot        <= '0;
            r_kwh        <= '0;
            r_power      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_mark       <= n_mark;
            r_lock       <= n_lock;
            r_lock_start <= n_lock_start;
            r_now        <= n_now;
            r_last       <= n_last;
            r_first      <= n_first;
            r_rot        <= n_rot;
            r_kwh        <= n_kwh;
            r_power      <= n_power;
            r_out_valid  <= n_out_valid;
            if ((r_state == ST_EVAL) && (r_in_act == ACT_SAMPLE)) begin
                r_win <= n_win;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_ROT_PER_KWH) begin
                    r_rpk <= i_cfg_data;
                end else if (i_cfg_index == REG_DEBOUNCE_MS) begin
                    r_deb <= i_cfg_data;
                end
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (s_xfer) begin
            r_in_act   <= s_axis_tuser;
            r_in_reads <= s_axis_tdata[4:0];
        end
        r_pvalid   <= n_pvalid;
        r_kstep    <= n_kstep;
        r_period   <= n_period;
        r_div      <= n_div;
        r_rem      <= n_rem;
        r_nq       <= n_nq;
        r_step     <= n_step;
        r_out_data <= n_out_data;
    end

endmodule

// ----- hdl/rmem_checker.sv -----
// ----------------------------------------------------------------------------
// rmem_checker
// Port-level checks of the rotation mark energy meter, bound to the top.
// ----------------------------------------------------------------------------
module rmem_checker
    import rmem_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   o_cfg_ready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // one item in work at a time
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // a power value comes only from a silver-to-red change, which locks
    a_power_on_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OB_PVALID] |->
            m_axis_tdata[OB_MARK] && m_axis_tdata[OB_LOCKED])
        else $error("power value without red mark and lockout");

    // a kWh step happens only with a measured rotation
    a_kstep_pvalid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[OB_KSTEP] |->
            m_axis_tdata[OB_PVALID] && (m_axis_tdata[OB_ROT +: 16] == 16'd1))
        else $error("kWh step without a rotation");

    // config writes never stall
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind rotation_mark_energy_meter rmem_checker u_rmem_checker (.*);
